[hw/rtl/hill_pkg.sv]
// Shared types and constants for the hazard incident latch and log.
`default_nettype none
package hill_pkg;
  localparam int unsigned NLatch       = 5;
  localparam int unsigned SlotsDefault = 10;
  localparam int unsigned IdW          = 32;
  localparam int unsigned TimeW        = 32;
  localparam int unsigned CfgW         = 16;
  localparam int unsigned CfgIdxW      = 3;

  localparam logic [CfgW-1:0] FrontConfirmRst = 16'd700;
  localparam logic [CfgW-1:0] RearConfirmRst  = 16'd700;
  localparam logic [CfgW-1:0] LeanConfirmRst  = 16'd500;
  localparam logic [CfgW-1:0] LaneConfirmRst  = 16'd500;
  localparam logic [CfgW-1:0] MultiConfirmRst = 16'd500;
  localparam logic [CfgW-1:0] CooldownRst     = 16'd5000;

  localparam logic [7:0] StateCritical = 8'd3;
  localparam logic [7:0] RiskCritical  = 8'd2;
  localparam logic [7:0] LaneLeft      = 8'd1;

  typedef enum logic [CfgIdxW-1:0] {
    REG_FRONT    = 3'd0,
    REG_REAR     = 3'd1,
    REG_LEAN     = 3'd2,
    REG_LANE     = 3'd3,
    REG_MULTI    = 3'd4,
    REG_COOLDOWN = 3'd5
  } cfg_reg_e;

  typedef enum logic [2:0] {
    EV_FRONT      = 3'd0,
    EV_REAR       = 3'd1,
    EV_LEAN       = 3'd2,
    EV_LANE_LEFT  = 3'd3,
    EV_LANE_RIGHT = 3'd4,
    EV_MULTI      = 3'd5
  } event_e;

  localparam logic [1:0] SevCritical = 2'd3;
  localparam logic [1:0] SevLane     = 2'd2;

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_EVAL   = 7'b0000010,
    S_PICK   = 7'b0000100,
    S_TSCAN  = 7'b0001000,
    S_EMIT   = 7'b0010000,
    S_ASCAN  = 7'b0100000,
    S_AREPLY = 7'b1000000
  } state_e;

  typedef struct packed {
    logic             en;
    logic [2:0]       idx;
    logic             act;
    logic [TimeW-1:0] now;
    logic [CfgW-1:0]  confirm;
    logic [CfgW-1:0]  cooldown;
  } latch_req_t;
endpackage
`default_nettype wire

[hw/rtl/hill_mem.sv]
// Incident table memory: id and time per slot, one write and one registered read port.
`default_nettype none
module hill_mem #(
  parameter int unsigned Slots = hill_pkg::SlotsDefault,
  parameter int unsigned SW    = 4,
  parameter int unsigned DW    = 64
) (
  input  wire logic          clk_i,
  input  wire logic          we_i,
  input  wire logic [SW-1:0] waddr_i,
  input  wire logic [DW-1:0] wdata_i,
  input  wire logic [SW-1:0] raddr_i,
  output logic      [DW-1:0] rdata_o
);
  logic [DW-1:0] mem_q [Slots];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule
`default_nettype wire

[hw/rtl/hill_latch.sv]
// Five hazard latches: start time, logged flag and last incident time, one latch per step.
`default_nettype none
module hill_latch (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire hill_pkg::latch_req_t req_i,
  output logic                      log_o
);
  logic [hill_pkg::TimeW-1:0] start_q [hill_pkg::NLatch];
  logic [hill_pkg::TimeW-1:0] last_q  [hill_pkg::NLatch];
  logic [hill_pkg::NLatch-1:0] logged_q;
  logic [hill_pkg::TimeW-1:0] start_eff, since_start, since_last;

  always_comb begin
    start_eff   = (start_q[req_i.idx] == '0) ? req_i.now : start_q[req_i.idx];
    since_start = req_i.now - start_eff;
    since_last  = req_i.now - last_q[req_i.idx];
    log_o = req_i.act && !logged_q[req_i.idx]
            && (since_start >= hill_pkg::TimeW'(req_i.confirm))
            && (since_last >= hill_pkg::TimeW'(req_i.cooldown));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < hill_pkg::NLatch; i++) begin
        start_q[i] <= '0;
        last_q[i]  <= '0;
      end
      logged_q <= '0;
    end else if (req_i.en) begin
      if (req_i.act) begin
        start_q[req_i.idx] <= start_eff;
        if (log_o) begin
          logged_q[req_i.idx] <= 1'b1;
          last_q[req_i.idx]   <= req_i.now;
        end
      end else begin
        start_q[req_i.idx]  <= '0;
        logged_q[req_i.idx] <= 1'b0;
      end
    end
  end
endmodule
`default_nettype wire

[hw/rtl/hazard_incident_latch_and_log.sv]
// Top level: hazard latches, incident table sequencer and output register.
// Tick: one latch step per hazard latch in S_EVAL, then per incident S_PICK takes a free slot or,
//   if the table is full, S_TSCAN scans the table memory for the oldest entry; S_EMIT then emits.
// Acknowledge: an id scan of the table memory in S_ASCAN, then the reply in S_AREPLY.
// One item at a time; a result waits in the output register while the next item runs.
// Reset (async, active low) clears latches, used flags, counters and config to defaults.
`default_nettype none
module hazard_incident_latch_and_log #(
  parameter int unsigned Slots = hill_pkg::SlotsDefault
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [2:0]  cfg_idx_i,
  input  wire logic [15:0] cfg_wdata_i,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic        mode_i,
  input  wire logic [31:0] now_ms_i,
  input  wire logic        front_online_i,
  input  wire logic [7:0]  front_state_i,
  input  wire logic        rear_online_i,
  input  wire logic [7:0]  rear_state_i,
  input  wire logic        lean_online_i,
  input  wire logic [7:0]  lean_risk_i,
  input  wire logic        lane_online_i,
  input  wire logic [7:0]  lane_state_i,
  input  wire logic [31:0] ack_id_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic             is_ack_reply_o,
  output logic             ack_hit_o,
  output logic [31:0]      incident_id_o,
  output logic [5:0]       slot_o,
  output logic [2:0]       event_code_o,
  output logic [1:0]       severity_o,
  output logic             evicted_o,
  output logic [31:0]      lost_total_o,
  output logic             last_o
);
  localparam int unsigned SW = (Slots > 1) ? $clog2(Slots) : 1;
  localparam int unsigned CW = $clog2(Slots + 1);
  localparam int unsigned NL = hill_pkg::NLatch;

  hill_pkg::state_e state_q, state_d;

  logic [hill_pkg::CfgW-1:0] confirm_q [NL];
  logic [hill_pkg::CfgW-1:0] cooldown_q;

  logic [31:0] now_q, ack_id_q;
  logic [7:0]  lane_q;
  logic [NL-1:0] act_q, mask_q, mask_d, lowbit;
  logic [2:0]  k_q, k_d, low_idx;
  logic [CW-1:0] cnt_q, cnt_d, prev;
  logic [31:0] best_time_q, best_time_d;
  logic [SW-1:0] best_slot_q, best_slot_d, free_idx, elem;
  logic        evict_q, evict_d, hit_q, hit_d;
  logic [Slots-1:0] used_q, used_d;
  logic [31:0] next_id_q, next_id_d, lost_q, lost_d;
  logic        out_free, inc_load, rep_load;
  logic        any_free;

  logic        mem_we;
  logic [SW-1:0] mem_raddr;
  logic [63:0] mem_rdata;

  hill_pkg::latch_req_t lreq;
  logic        lat_log;

  logic [2:0]  ev_code;
  logic [1:0]  ev_sev;

  // latch unit
  always_comb begin
    lreq.en       = state_q == hill_pkg::S_EVAL;
    lreq.idx      = k_q;
    lreq.act      = act_q[k_q];
    lreq.now      = now_q;
    lreq.confirm  = confirm_q[k_q];
    lreq.cooldown = cooldown_q;
  end

  hill_latch u_latch (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (lreq),
    .log_o  (lat_log)
  );

  hill_mem #(.Slots(Slots), .SW(SW), .DW(64)) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (best_slot_q),
    .wdata_i ({next_id_q, now_q}),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  always_comb begin
    free_idx = '0;
    for (int i = Slots - 1; i >= 0; i--) begin
      if (!used_q[i]) free_idx = SW'(i);
    end
    any_free = ~&used_q;
    lowbit   = mask_q & (~mask_q + NL'(1));
    low_idx  = '0;
    for (int i = NL - 1; i >= 0; i--) begin
      if (mask_q[i]) low_idx = 3'(i);
    end
    case (low_idx)
      3'd0:    ev_code = hill_pkg::EV_FRONT;
      3'd1:    ev_code = hill_pkg::EV_REAR;
      3'd2:    ev_code = hill_pkg::EV_LEAN;
      3'd3:    ev_code = (lane_q == hill_pkg::LaneLeft) ? hill_pkg::EV_LANE_LEFT
                                                        : hill_pkg::EV_LANE_RIGHT;
      default: ev_code = hill_pkg::EV_MULTI;
    endcase
    ev_sev = (low_idx == 3'd3) ? hill_pkg::SevLane : hill_pkg::SevCritical;
  end

  assign in_stall_o = state_q != hill_pkg::S_IDLE;
  assign out_free   = !out_valid_o || !out_stall_i;
  assign prev       = cnt_q - CW'(1);
  assign elem       = prev[SW-1:0];
  assign mem_raddr  = cnt_q[SW-1:0];

  always_comb begin
    state_d     = state_q;
    k_d         = k_q;
    mask_d      = mask_q;
    cnt_d       = cnt_q;
    best_time_d = best_time_q;
    best_slot_d = best_slot_q;
    evict_d     = evict_q;
    hit_d       = hit_q;
    used_d      = used_q;
    next_id_d   = next_id_q;
    lost_d      = lost_q;
    mem_we      = 1'b0;
    inc_load    = 1'b0;
    rep_load    = 1'b0;
    case (state_q)
      hill_pkg::S_IDLE: begin
        if (in_valid_i) begin
          k_d    = '0;
          mask_d = '0;
          cnt_d  = '0;
          hit_d  = 1'b0;
          state_d = mode_i ? hill_pkg::S_ASCAN : hill_pkg::S_EVAL;
        end
      end
      hill_pkg::S_EVAL: begin
        mask_d[k_q] = lat_log;
        k_d = k_q + 3'd1;
        if (k_q == 3'(NL - 1)) begin
          state_d = (mask_d == '0) ? hill_pkg::S_IDLE : hill_pkg::S_PICK;
        end
      end
      hill_pkg::S_PICK: begin
        if (any_free) begin
          best_slot_d = free_idx;
          evict_d     = 1'b0;
          state_d     = hill_pkg::S_EMIT;
        end else begin
          evict_d = 1'b1;
          cnt_d   = '0;
          state_d = hill_pkg::S_TSCAN;
        end
      end
      hill_pkg::S_TSCAN: begin
        if (cnt_q != '0) begin
          if (cnt_q == CW'(1) || mem_rdata[31:0] < best_time_q) begin
            best_time_d = mem_rdata[31:0];
            best_slot_d = elem;
          end
        end
        cnt_d = cnt_q + CW'(1);
        if (cnt_q == CW'(Slots)) state_d = hill_pkg::S_EMIT;
      end
      hill_pkg::S_EMIT: begin
        if (out_free) begin
          mem_we    = 1'b1;
          inc_load  = 1'b1;
          used_d[best_slot_q] = 1'b1;
          next_id_d = next_id_q + 32'd1;
          if (evict_q) lost_d = lost_q + 32'd1;
          mask_d  = mask_q & ~lowbit;
          state_d = (mask_d == '0) ? hill_pkg::S_IDLE : hill_pkg::S_PICK;
        end
      end
      hill_pkg::S_ASCAN: begin
        if (cnt_q != '0) begin
          if (!hit_q && used_q[elem] && mem_rdata[63:32] == ack_id_q) begin
            hit_d       = 1'b1;
            best_slot_d = elem;
          end
        end
        cnt_d = cnt_q + CW'(1);
        if (cnt_q == CW'(Slots)) state_d = hill_pkg::S_AREPLY;
      end
      hill_pkg::S_AREPLY: begin
        if (out_free) begin
          rep_load = 1'b1;
          if (hit_q) used_d[best_slot_q] = 1'b0;
          state_d = hill_pkg::S_IDLE;
        end
      end
      default: state_d = hill_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= hill_pkg::S_IDLE;
      confirm_q[0]  <= hill_pkg::FrontConfirmRst;
      confirm_q[1]  <= hill_pkg::RearConfirmRst;
      confirm_q[2]  <= hill_pkg::LeanConfirmRst;
      confirm_q[3]  <= hill_pkg::LaneConfirmRst;
      confirm_q[4]  <= hill_pkg::MultiConfirmRst;
      cooldown_q    <= hill_pkg::CooldownRst;
      used_q        <= '0;
      next_id_q     <= 32'd1;
      lost_q        <= '0;
      out_valid_o   <= 1'b0;
      k_q           <= '0;
      mask_q        <= '0;
      cnt_q         <= '0;
      evict_q       <= 1'b0;
      hit_q         <= 1'b0;
    end else begin
      state_q   <= state_d;
      used_q    <= used_d;
      next_id_q <= next_id_d;
      lost_q    <= lost_d;
      k_q       <= k_d;
      mask_q    <= mask_d;
      cnt_q     <= cnt_d;
      evict_q   <= evict_d;
      hit_q     <= hit_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          hill_pkg::REG_FRONT:    confirm_q[0] <= cfg_wdata_i;
          hill_pkg::REG_REAR:     confirm_q[1] <= cfg_wdata_i;
          hill_pkg::REG_LEAN:     confirm_q[2] <= cfg_wdata_i;
          hill_pkg::REG_LANE:     confirm_q[3] <= cfg_wdata_i;
          hill_pkg::REG_MULTI:    confirm_q[4] <= cfg_wdata_i;
          hill_pkg::REG_COOLDOWN: cooldown_q   <= cfg_wdata_i;
          default: ;
        endcase
      end
      if (inc_load || rep_load) out_valid_o <= 1'b1;
      else if (!out_stall_i)    out_valid_o <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    best_time_q <= best_time_d;
    best_slot_q <= best_slot_d;
    if (state_q == hill_pkg::S_IDLE && in_valid_i) begin
      now_q    <= now_ms_i;
      ack_id_q <= ack_id_i;
      lane_q   <= lane_state_i;
      act_q[0] <= front_online_i && front_state_i == hill_pkg::StateCritical;
      act_q[1] <= rear_online_i && rear_state_i == hill_pkg::StateCritical;
      act_q[2] <= lean_online_i && lean_risk_i == hill_pkg::RiskCritical;
      act_q[3] <= lane_online_i && lane_state_i != 8'd0;
      act_q[4] <= ((3'(front_online_i && front_state_i == hill_pkg::StateCritical))
                 + (3'(rear_online_i && rear_state_i == hill_pkg::StateCritical))
                 + (3'(lean_online_i && lean_risk_i == hill_pkg::RiskCritical))
                 + (3'(lane_online_i && lane_state_i != 8'd0))) >= 3'd2;
    end
    if (inc_load) begin
      is_ack_reply_o <= 1'b0;
      ack_hit_o      <= 1'b0;
      incident_id_o  <= next_id_q;
      slot_o         <= 6'(best_slot_q);
      event_code_o   <= ev_code;
      severity_o     <= ev_sev;
      evicted_o      <= evict_q;
      lost_total_o   <= lost_d;
      last_o         <= mask_d == '0;
    end else if (rep_load) begin
      is_ack_reply_o <= 1'b1;
      ack_hit_o      <= hit_q;
      incident_id_o  <= '0;
      slot_o         <= '0;
      event_code_o   <= '0;
      severity_o     <= '0;
      evicted_o      <= 1'b0;
      lost_total_o   <= '0;
      last_o         <= 1'b1;
    end
  end

  a_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni) $onehot(state_q))
    else $error("state not one-hot");
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("accepted word did not start work");
  a_id: assert property (@(posedge clk_i) disable iff (!rst_ni)
    inc_load |=> next_id_q == $past(next_id_q) + 32'd1)
    else $error("id not advanced");
  a_used: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == hill_pkg::S_TSCAN |-> used_q == '1)
    else $error("oldest scan with a free slot");
endmodule
`default_nettype wire

[tb/sv/tb_hazard_incident_latch_and_log.sv]
// Self-checking testbench for hazard_incident_latch_and_log: table, random ticks/acks, predictor.
`timescale 1ns / 100ps
`default_nettype none
module tb_hazard_incident_latch_and_log;
  import hill_pkg::*;

  localparam logic MODE_TICK = 1'b0;
  localparam logic MODE_ACK  = 1'b1;
  localparam int unsigned NSLOT     = SlotsDefault;
  localparam int unsigned LIMIT     = 600000;
  localparam int unsigned SETTLE    = 120;
  localparam int unsigned N_PHASE   = 4;
  localparam int unsigned PER_PHASE = 125;

  typedef struct {
    logic        mode;
    logic [31:0] now;
    logic        f_on;
    logic [7:0]  f_st;
    logic        r_on;
    logic [7:0]  r_st;
    logic        l_on;
    logic [7:0]  l_risk;
    logic        ln_on;
    logic [7:0]  ln_st;
    logic [31:0] ack;
  } hz_item_t;

  typedef struct {
    logic        is_ack;
    logic        hit;
    logic [31:0] id;
    logic [5:0]  slot;
    event_e      code;
    logic [1:0]  sev;
    logic        ev;
    logic [31:0] lost;
    logic        last;
  } log_word_t;

  typedef struct {
    hz_item_t item;
    logic     typed;
    logic     typed_hit;
  } dir_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [2:0]  cfg_idx_i = '0;
  logic [15:0] cfg_wdata_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic        mode_i = 1'b0;
  logic [31:0] now_ms_i = '0;
  logic        front_online_i = 1'b0;
  logic [7:0]  front_state_i = '0;
  logic        rear_online_i = 1'b0;
  logic [7:0]  rear_state_i = '0;
  logic        lean_online_i = 1'b0;
  logic [7:0]  lean_risk_i = '0;
  logic        lane_online_i = 1'b0;
  logic [7:0]  lane_state_i = '0;
  logic [31:0] ack_id_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b1;
  logic        is_ack_reply_o;
  logic        ack_hit_o;
  logic [31:0] incident_id_o;
  logic [5:0]  slot_o;
  logic [2:0]  event_code_o;
  logic [1:0]  severity_o;
  logic        evicted_o;
  logic [31:0] lost_total_o;
  logic        last_o;

  hazard_incident_latch_and_log u_dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_wdata_i,
    .in_valid_i, .in_stall_o, .mode_i, .now_ms_i,
    .front_online_i, .front_state_i, .rear_online_i, .rear_state_i,
    .lean_online_i, .lean_risk_i, .lane_online_i, .lane_state_i, .ack_id_i,
    .out_valid_o, .out_stall_i, .is_ack_reply_o, .ack_hit_o, .incident_id_o,
    .slot_o, .event_code_o, .severity_o, .evicted_o, .lost_total_o, .last_o
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // predictor state
  logic [15:0] confirm_ms [NLatch];
  logic [15:0] cooldown;
  logic [31:0] lt_start [NLatch];
  logic        lt_logged [NLatch];
  logic [31:0] lt_last [NLatch];
  logic        tbl_used [NSLOT];
  logic        tbl_pend [NSLOT];
  logic [31:0] tbl_id [NSLOT];
  logic [31:0] tbl_time [NSLOT];
  logic [31:0] id_next;
  logic [31:0] lost_cnt;

  log_word_t   incident_q[$];
  int unsigned errors = 0;
  int unsigned cycles = 0;
  logic        sent_done = 1'b0;

  // random tick shaping
  logic        hz_on [4];
  logic        lane_left;
  logic [31:0] clock_ms;

  initial begin
    for (int i = 0; i < int'(NLatch); i++) begin
      lt_start[i] = '0; lt_logged[i] = 1'b0; lt_last[i] = '0;
    end
    for (int i = 0; i < int'(NSLOT); i++) begin
      tbl_used[i] = 1'b0; tbl_pend[i] = 1'b0; tbl_time[i] = '0; tbl_id[i] = '0;
    end
    confirm_ms[0] = FrontConfirmRst; confirm_ms[1] = RearConfirmRst;
    confirm_ms[2] = LeanConfirmRst;  confirm_ms[3] = LaneConfirmRst;
    confirm_ms[4] = MultiConfirmRst; cooldown = CooldownRst;
    id_next = 32'd1;
    lost_cnt = '0;
    for (int i = 0; i < 4; i++) hz_on[i] = 1'b0;
    lane_left = 1'b1;
    clock_ms = 32'd1000;
  end

  function automatic int unsigned choose_slot(output logic ev);
    int unsigned best;
    best = 0;
    ev = 1'b0;
    for (int i = 0; i < int'(NSLOT); i++) if (!tbl_used[i]) return i;
    for (int i = 0; i < int'(NSLOT); i++) if (!tbl_pend[i]) return i;
    for (int i = 1; i < int'(NSLOT); i++) if (tbl_time[i] < tbl_time[best]) best = i;
    lost_cnt = lost_cnt + 1;
    ev = 1'b1;
    return best;
  endfunction

  // Pushes the words an accepted item causes; returns the predicted ack hit.
  function automatic logic log_incidents(hz_item_t it, logic push);
    logic        act [NLatch];
    int unsigned cnt, s, first;
    logic        hit, ev;
    log_word_t   w;
    first = incident_q.size();
    hit = 1'b0;
    if (it.mode == MODE_ACK) begin
      for (int k = 0; k < int'(NSLOT); k++) begin
        if (tbl_used[k] && tbl_id[k] == it.ack) begin
          tbl_used[k] = 1'b0; tbl_pend[k] = 1'b0; hit = 1'b1;
          break;
        end
      end
      w = '{is_ack: 1'b1, hit: hit, id: '0, slot: '0, code: EV_FRONT, sev: '0,
            ev: 1'b0, lost: '0, last: 1'b1};
      if (push) incident_q.push_back(w);
      return hit;
    end
    act[0] = it.f_on && it.f_st == StateCritical;
    act[1] = it.r_on && it.r_st == StateCritical;
    act[2] = it.l_on && it.l_risk == RiskCritical;
    act[3] = it.ln_on && it.ln_st != 8'd0;
    cnt = act[0] + act[1] + act[2] + act[3];
    act[4] = cnt >= 2;
    for (int k = 0; k < int'(NLatch); k++) begin
      if (act[k]) begin
        if (lt_start[k] == 0) lt_start[k] = it.now;
        if (!lt_logged[k] && (it.now - lt_start[k]) >= {16'd0, confirm_ms[k]} &&
            (it.now - lt_last[k]) >= {16'd0, cooldown}) begin
          s = choose_slot(ev);
          tbl_used[s] = 1'b1; tbl_pend[s] = 1'b1;
          tbl_id[s] = id_next; tbl_time[s] = it.now;
          w.is_ack = 1'b0; w.hit = 1'b0; w.id = id_next; w.slot = 6'(s);
          w.sev = SevCritical;
          case (k)
            0: w.code = EV_FRONT;
            1: w.code = EV_REAR;
            2: w.code = EV_LEAN;
            3: begin
              w.code = (it.ln_st == LaneLeft) ? EV_LANE_LEFT : EV_LANE_RIGHT;
              w.sev = SevLane;
            end
            default: w.code = EV_MULTI;
          endcase
          w.ev = ev; w.lost = lost_cnt; w.last = 1'b0;
          incident_q.push_back(w);
          id_next = id_next + 1;
          lt_logged[k] = 1'b1;
          lt_last[k] = it.now;
        end
      end else begin
        lt_start[k] = '0;
        lt_logged[k] = 1'b0;
      end
    end
    if (incident_q.size() > first) incident_q[incident_q.size()-1].last = 1'b1;
    return 1'b0;
  endfunction

  function automatic hz_item_t tick(logic [31:0] t, logic fc, logic rc, logic lc,
                                    logic [7:0] lane);
    hz_item_t it;
    it = '{mode: MODE_TICK, now: t, f_on: 1'b1, f_st: fc ? StateCritical : 8'd0,
           r_on: 1'b1, r_st: rc ? StateCritical : 8'd1, l_on: 1'b1,
           l_risk: lc ? RiskCritical : 8'd1, ln_on: 1'b1, ln_st: lane, ack: '0};
    return it;
  endfunction

  function automatic hz_item_t ack_of(logic [31:0] id);
    hz_item_t it;
    it = '{mode: MODE_ACK, now: $urandom, f_on: 1'b0, f_st: '0, r_on: 1'b0, r_st: '0,
           l_on: 1'b0, l_risk: '0, ln_on: 1'b0, ln_st: '0, ack: id};
    return it;
  endfunction

  function automatic logic [7:0] not_val(logic [7:0] v);
    logic [7:0] r;
    r = 8'($urandom);
    return (r == v) ? ~v : r;
  endfunction

  function automatic hz_item_t rand_item();
    hz_item_t it;
    int unsigned p;
    p = $urandom_range(0, 99);
    if (p < 15) begin
      if (p < 3 || id_next == 1) return ack_of($urandom);
      return ack_of(id_next - $urandom_range(1, (id_next > 20) ? 20 : id_next - 1));
    end
    p = $urandom_range(0, 99);
    if (p < 2) clock_ms = 32'hFFFF_FFFF - $urandom_range(0, 3000);
    else if (p < 4) clock_ms = 32'd0;
    else if (p < 6) clock_ms = $urandom;
    else if (p < 12) clock_ms = clock_ms + $urandom_range(5000, 70000);
    else if (p < 17) clock_ms = clock_ms;
    else clock_ms = clock_ms + $urandom_range(1, 400);
    for (int i = 0; i < 4; i++) if ($urandom_range(0, 9) == 0) hz_on[i] = !hz_on[i];
    if ($urandom_range(0, 15) == 0) lane_left = !lane_left;
    it.mode = MODE_TICK;
    it.now = clock_ms;
    it.ack = $urandom;
    it.f_on = hz_on[0] | 1'($urandom);
    it.f_st = hz_on[0] ? StateCritical : (it.f_on ? not_val(StateCritical) : 8'($urandom));
    it.f_on = hz_on[0] ? 1'b1 : it.f_on;
    it.r_on = hz_on[1] | 1'($urandom);
    it.r_st = hz_on[1] ? StateCritical : (it.r_on ? not_val(StateCritical) : 8'($urandom));
    it.r_on = hz_on[1] ? 1'b1 : it.r_on;
    it.l_on = hz_on[2] | 1'($urandom);
    it.l_risk = hz_on[2] ? RiskCritical : (it.l_on ? not_val(RiskCritical) : 8'($urandom));
    it.l_on = hz_on[2] ? 1'b1 : it.l_on;
    it.ln_on = hz_on[3] | 1'($urandom);
    if (hz_on[3]) it.ln_st = lane_left ? LaneLeft : 8'($urandom_range(2, 255));
    else it.ln_st = it.ln_on ? 8'd0 : 8'($urandom);
    it.ln_on = hz_on[3] ? 1'b1 : it.ln_on;
    return it;
  endfunction

  int unsigned burst_left = 0;

  task automatic send(hz_item_t it);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
      burst_left = $urandom_range(1, 30);
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    mode_i <= it.mode; now_ms_i <= it.now; ack_id_i <= it.ack;
    front_online_i <= it.f_on; front_state_i <= it.f_st;
    rear_online_i <= it.r_on; rear_state_i <= it.r_st;
    lean_online_i <= it.l_on; lean_risk_i <= it.l_risk;
    lane_online_i <= it.ln_on; lane_state_i <= it.ln_st;
    in_valid_i <= 1'b1;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    burst_left = 0;
    while (incident_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_reg_e idx, logic [15:0] v);
    cfg_we_i <= 1'b1; cfg_idx_i <= idx; cfg_wdata_i <= v;
    @(posedge clk_i);
    if (idx == REG_COOLDOWN) cooldown = v;
    else confirm_ms[idx] = v;
  endtask

  task automatic apply_phase(int unsigned ph);
    logic [15:0] v;
    for (int r = 0; r <= int'(REG_COOLDOWN); r++) begin
      case (ph)
        1: v = 16'd0;
        2: v = 16'hFFFF;
        default: v = 16'($urandom_range(0, 2500));
      endcase
      write_reg(cfg_reg_e'(r), v);
    end
    cfg_we_i <= 1'b0;
  endtask

  // receiver stall pattern, with one long hold-off
  initial begin
    int unsigned seg, mode;
    @(posedge rst_ni);
    forever begin
      if (cycles > 4000 && cycles < 4400) begin
        out_stall_i <= 1'b1;
        repeat (1500) @(posedge clk_i);
      end
      seg = $urandom_range(10, 200);
      mode = $urandom_range(0, 3);
      repeat (seg) begin
        case (mode)
          0: out_stall_i <= 1'b0;
          1: out_stall_i <= ($urandom_range(0, 9) < 3);
          2: out_stall_i <= ($urandom_range(0, 9) < 7);
          default: out_stall_i <= ($urandom_range(0, 1) == 0);
        endcase
        @(posedge clk_i);
      end
    end
  end

  always @(posedge clk_i) begin
    log_word_t w;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (incident_q.size() == 0) begin
        $error("unexpected word: id %0d ack %0b", incident_id_o, is_ack_reply_o);
        errors++;
      end else begin
        w = incident_q.pop_front();
        if (is_ack_reply_o !== w.is_ack) begin
          $error("is_ack_reply exp %0d got %0d", w.is_ack, is_ack_reply_o); errors++;
        end
        if (ack_hit_o !== w.hit) begin
          $error("ack_hit exp %0d got %0d", w.hit, ack_hit_o); errors++;
        end
        if (incident_id_o !== w.id) begin
          $error("incident_id exp %0d got %0d", w.id, incident_id_o); errors++;
        end
        if (slot_o !== w.slot) begin
          $error("slot exp %0d got %0d", w.slot, slot_o); errors++;
        end
        if (event_code_o !== w.code) begin
          $error("event_code exp %0d got %0d", w.code, event_code_o); errors++;
        end
        if (severity_o !== w.sev) begin
          $error("severity exp %0d got %0d", w.sev, severity_o); errors++;
        end
        if (evicted_o !== w.ev) begin
          $error("evicted exp %0d got %0d", w.ev, evicted_o); errors++;
        end
        if (lost_total_o !== w.lost) begin
          $error("lost_total exp %0d got %0d", w.lost, lost_total_o); errors++;
        end
        if (last_o !== w.last) begin
          $error("last exp %0d got %0d", w.last, last_o); errors++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == LIMIT) begin
      $display("** hazard_incident_latch_and_log: FAILED **");
      $finish;
    end
  end

  dir_row_t dir_tbl[$];

  initial begin
    hz_item_t it;
    dir_tbl.push_back('{ack_of(32'd5), 1'b1, 1'b0});
    dir_tbl.push_back('{tick(32'd0, 1, 0, 0, 8'd0), 1'b0, 1'b0});
    dir_tbl.push_back('{tick(32'd100, 1, 0, 0, 8'd0), 1'b0, 1'b0});
    dir_tbl.push_back('{tick(32'd6000, 1, 1, 0, 8'd0), 1'b0, 1'b0});
    dir_tbl.push_back('{tick(32'd6800, 1, 1, 1, LaneLeft), 1'b0, 1'b0});
    dir_tbl.push_back('{tick(32'd7400, 1, 1, 1, 8'd255), 1'b0, 1'b0});
    dir_tbl.push_back('{ack_of(32'd1), 1'b1, 1'b1});
    dir_tbl.push_back('{ack_of(32'd1), 1'b1, 1'b0});
    dir_tbl.push_back('{ack_of(32'hFFFF_FFFF), 1'b1, 1'b0});
    it = tick(32'd7500, 0, 0, 0, 8'd0);
    it.f_on = 1'b0; it.f_st = StateCritical; it.r_on = 1'b0; it.r_st = 8'hFF;
    it.l_on = 1'b0; it.l_risk = RiskCritical; it.ln_on = 1'b0; it.ln_st = 8'hFF;
    dir_tbl.push_back('{it, 1'b0, 1'b0});
    dir_tbl.push_back('{tick(32'hFFFF_FFF0, 1, 1, 1, 8'd2), 1'b0, 1'b0});
    dir_tbl.push_back('{tick(32'h0000_02F0, 1, 1, 1, 8'd2), 1'b0, 1'b0});
    dir_tbl.push_back('{tick(32'h0000_1800, 1, 1, 1, 8'd2), 1'b0, 1'b0});
    dir_tbl.push_back('{ack_of(32'd6), 1'b0, 1'b0});

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    foreach (dir_tbl[i]) begin
      send(dir_tbl[i].item);
      void'(log_incidents(dir_tbl[i].item, !dir_tbl[i].typed));
      if (dir_tbl[i].typed)
        incident_q.push_back('{is_ack: 1'b1, hit: dir_tbl[i].typed_hit, id: '0, slot: '0,
                               code: EV_FRONT, sev: '0, ev: 1'b0, lost: '0, last: 1'b1});
    end
    for (int ph = 0; ph < int'(N_PHASE); ph++) begin
      if (ph > 0) begin
        drain();
        apply_phase(ph);
      end
      for (int n = 0; n < int'(PER_PHASE); n++) begin
        it = rand_item();
        if (ph == 2 && it.mode == MODE_TICK && $urandom_range(0, 3) == 0) begin
          clock_ms = clock_ms + 32'd33000;
          it.now = clock_ms;
        end
        send(it);
        void'(log_incidents(it, 1'b1));
      end
    end
    drain();
    if (errors == 0) begin
      $display("** hazard_incident_latch_and_log: PASSED **");
    end else begin
      $display("** hazard_incident_latch_and_log: FAILED **");
    end
    $finish;
  end
endmodule
`default_nettype wire

[sim.f]
hw/rtl/hill_pkg.sv
hw/rtl/hill_mem.sv
hw/rtl/hill_latch.sv
hw/rtl/hazard_incident_latch_and_log.sv
tb/sv/tb_hazard_incident_latch_and_log.sv
